// ===== design/fpd_pkg.sv =====
// ============================================================================
// fpd_pkg: shared constants, types and helpers for the four pixel stego codec.
// Holds the candidate digit decoding and per-candidate check functions.
// ============================================================================
package fpd_pkg;

    localparam int MAX_K_DEF = 5;
    localparam int NUM_CAND  = 81;

    // Configuration register indexes.
    localparam logic [1:0] REG_K_LOW     = 2'd0;
    localparam logic [1:0] REG_K_HIGH    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic CMD_EMBED   = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    typedef logic [7:0] t_pix;
    typedef t_pix [3:0] t_quad;

    // Sum of differences from the minimum, at most 3*255.
    function automatic logic [9:0] sum_diff(input t_quad p);
        logic [7:0] mn;
        logic [9:0] s;
        mn = p[0];
        for (int i = 1; i < 4; i++) if (p[i] < mn) mn = p[i];
        s = '0;
        for (int i = 0; i < 4; i++) s = s + 10'(p[i] - mn);
        return s;
    endfunction

    function automatic logic [7:0] quad_range(input t_quad p);
        logic [7:0] mn;
        logic [7:0] mx;
        mn = p[0];
        mx = p[0];
        for (int i = 1; i < 4; i++) begin
            if (p[i] < mn) mn = p[i];
            if (p[i] > mx) mx = p[i];
        end
        return mx - mn;
    endfunction

    // Smooth when 3t >= sum.
    function automatic logic is_smooth(input logic [9:0] s, input logic [5:0] t);
        logic [7:0] t3;
        t3 = 8'({2'b0, t} + {1'b0, t, 1'b0});
        return {2'b0, t3} >= s;
    endfunction

    function automatic logic is_err(input t_quad p, input logic smooth, input logic [5:0] t);
        logic [7:0] lim;
        lim = {1'b0, t, 1'b0} + 8'd2;
        return smooth && (quad_range(p) > lim);
    endfunction

    // Digit of candidate idx for pixel j (pixel 0 most significant), 0..2.
    function automatic logic [1:0] cand_digit(input int idx, input int j);
        int r;
        r = idx;
        for (int q = 3; q > j; q--) r = r / 3;
        return 2'(r % 3);
    endfunction

endpackage

// ===== design/fpd_classify.sv =====
// ============================================================================
// fpd_classify: stage one and two of the codec.
// Classifies the block, builds the modified-LSB quad and the extracted word.
// ============================================================================
module fpd_classify #(
    parameter int MAX_K = fpd_pkg::MAX_K_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic             i_cmd,
    input  fpd_pkg::t_quad   i_pix,
    input  logic [19:0]      i_msg,
    input  logic [2:0]       i_k_low,
    input  logic [2:0]       i_k_high,
    input  logic [5:0]       i_thr,
    output logic             o_valid,
    output logic             o_cmd,
    output logic             o_skip,
    output logic             o_smooth,
    output logic [2:0]       o_k,
    output fpd_pkg::t_quad   o_pix,
    output fpd_pkg::t_quad   o_lsb,
    output logic [19:0]      o_ext
);
    import fpd_pkg::*;

    // Stage A registers: class and k.
    logic           r_a_valid, r_a_cmd, r_a_smooth, r_a_err;
    logic [2:0]     r_a_k;
    t_quad          r_a_pix;
    logic [19:0]    r_a_msg;
    logic [9:0]     n_sum;
    logic           n_smooth;
    logic [2:0]     n_k;

    always_comb begin
        n_sum    = sum_diff(i_pix);
        n_smooth = is_smooth(n_sum, i_thr);
        n_k      = n_smooth ? i_k_low : i_k_high;
        if (n_k == 3'd0) n_k = 3'd1;
        if (n_k > 3'(MAX_K)) n_k = 3'(MAX_K);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_a_cmd    <= i_cmd;
            r_a_smooth <= n_smooth;
            r_a_err    <= is_err(i_pix, n_smooth, i_thr);
            r_a_k      <= n_k;
            r_a_pix    <= i_pix;
            r_a_msg    <= i_msg;
        end
    end

    // Stage B: modified-LSB insertion and extraction.
    t_quad       n_lsb;
    logic [19:0] n_ext;
    always_comb begin
        logic [7:0] mask;
        logic [8:0] l, a, b;
        logic [7:0] chunk;
        logic [34:0] ext_w;
        mask  = 8'((9'd1 << r_a_k) - 9'd1);
        a     = 9'd1 << (r_a_k - 3'd1);
        b     = 9'd1 << r_a_k;
        ext_w = '0;
        for (int i = 0; i < 4; i++) begin
            chunk = 8'(r_a_msg >> (5'(r_a_k) * 5'(i))) & mask;
            l = {1'b0, (r_a_pix[i] & ~mask) | chunk};
            n_lsb[i] = l[7:0];
            if (l > {1'b0, r_a_pix[i]} && (l - {1'b0, r_a_pix[i]}) > a) begin
                if (l >= b) n_lsb[i] = 8'(l - b);
            end else if ({1'b0, r_a_pix[i]} > l && ({1'b0, r_a_pix[i]} - l) > a) begin
                if (l < 9'd256 - b) n_lsb[i] = 8'(l + b);
            end
            ext_w = ext_w | (35'(r_a_pix[i] & mask) << (5'(r_a_k) * 5'(i)));
        end
        n_ext = ext_w[19:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_a_valid;
        end
        if (i_en) begin
            o_cmd    <= r_a_cmd;
            o_skip   <= r_a_err;
            o_smooth <= r_a_smooth;
            o_k      <= r_a_k;
            o_pix    <= r_a_pix;
            o_lsb    <= n_lsb;
            o_ext    <= n_ext;
        end
    end
endmodule

// ===== design/fpd_search.sv =====
// ============================================================================
// fpd_search: candidate search over the 81 readjusted quads.
// Stage C scores every candidate in its own lane; stage D picks the best.
// ============================================================================
module fpd_search (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic             i_smooth,
    input  logic [2:0]       i_k,
    input  logic [5:0]       i_thr,
    input  fpd_pkg::t_quad   i_pix,
    input  fpd_pkg::t_quad   i_lsb,
    output logic             o_valid,
    output fpd_pkg::t_quad   o_best
);
    import fpd_pkg::*;

    // Stage C: one lane per candidate, registered ok flag and error.
    logic [NUM_CAND-1:0] r_ok;
    logic [17:0]         r_sd [NUM_CAND];
    t_quad               r_cand [NUM_CAND];
    t_quad               r_lsb;
    logic                r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) r_lsb <= i_lsb;
    end

    for (genvar c = 0; c < NUM_CAND; c++) begin : g_lane
        t_quad       n_cand;
        logic        n_ok;
        logic [17:0] n_sd;
        always_comb begin
            logic [9:0]  v;
            logic [9:0]  s;
            logic [8:0]  d;
            logic [8:0]  step;
            logic        cs;
            step = 9'd1 << i_k;
            n_ok = 1'b1;
            n_sd = '0;
            for (int j = 0; j < 4; j++) begin
                case (cand_digit(c, j))
                    2'd1:    v = {2'b0, i_lsb[j]} + {1'b0, step};
                    2'd2:    v = {2'b0, i_lsb[j]} - {1'b0, step};
                    default: v = {2'b0, i_lsb[j]};
                endcase
                if (v[9:8] != 2'b00) n_ok = 1'b0;
                n_cand[j] = v[7:0];
                d = (v[7:0] >= i_pix[j]) ? 9'(v[7:0] - i_pix[j]) : 9'(i_pix[j] - v[7:0]);
                n_sd = n_sd + (18'(d) * 18'(d));
            end
            s  = sum_diff(n_cand);
            cs = is_smooth(s, i_thr);
            if (cs != i_smooth) n_ok = 1'b0;
            if (is_err(n_cand, cs, i_thr)) n_ok = 1'b0;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ok[c]   <= n_ok;
                r_sd[c]   <= n_sd;
                r_cand[c] <= n_cand;
            end
        end
    end

    // Stage D: first-wins minimum over the lanes as a tree.
    localparam int LV = 7;
    localparam int W  = 128;
    logic        t_ok [LV+1][W];
    logic [17:0] t_sd [LV+1][W];
    t_quad       t_q  [LV+1][W];

    always_comb begin
        for (int c = 0; c < W; c++) begin
            t_ok[0][c] = (c < NUM_CAND) ? r_ok[c % NUM_CAND] : 1'b0;
            t_sd[0][c] = r_sd[c % NUM_CAND];
            t_q[0][c]  = r_cand[c % NUM_CAND];
        end
        for (int l = 1; l <= LV; l++) begin
            for (int c = 0; c < W; c++) begin
                t_ok[l][c] = 1'b0;
                t_sd[l][c] = '0;
                t_q[l][c]  = '0;
            end
            for (int c = 0; c < (W >> l); c++) begin
                if (t_ok[l-1][2*c] &&
                    (!t_ok[l-1][2*c+1] || t_sd[l-1][2*c] <= t_sd[l-1][2*c+1])) begin
                    t_ok[l][c] = 1'b1;
                    t_sd[l][c] = t_sd[l-1][2*c];
                    t_q[l][c]  = t_q[l-1][2*c];
                end else begin
                    t_ok[l][c] = t_ok[l-1][2*c+1];
                    t_sd[l][c] = t_sd[l-1][2*c+1];
                    t_q[l][c]  = t_q[l-1][2*c+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_valid;
        end
        if (i_en) o_best <= t_ok[LV][0] ? t_q[LV][0] : r_lsb;
    end
endmodule

// ===== design/four_pixel_diff_stego_codec_core.sv =====
// ============================================================================
// four_pixel_diff_stego_codec_core: 2x2 block stego embed and extract codec.
// Five register stages; one word in and one word out per cycle unless i_stall holds the output.
//
//   channel | handshake          | payload
//   in      | i_valid / o_stall  | cmd, four pixels, msg_bits
//   out     | o_valid / i_stall  | skip, four pixels, bits_used, extracted
//   cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word per cycle is taken while the pipeline is not frozen.
// The output register holds a word while i_stall is high and the whole
// pipeline freezes; the input takes a word whenever output can move.
// Synchronous active-low reset clears valid bits; registers reset to 2, 3, 6.
// ============================================================================
module four_pixel_diff_stego_codec_core #(
    parameter int MAX_K = fpd_pkg::MAX_K_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_pix_top_left,
    input  logic [7:0]  i_pix_top_right,
    input  logic [7:0]  i_pix_bottom_left,
    input  logic [7:0]  i_pix_bottom_right,
    input  logic [19:0] i_msg_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_skip_block,
    output logic [7:0]  o_out_top_left,
    output logic [7:0]  o_out_top_right,
    output logic [7:0]  o_out_bottom_left,
    output logic [7:0]  o_out_bottom_right,
    output logic [4:0]  o_bits_used,
    output logic [19:0] o_extracted_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import fpd_pkg::*;

    logic [2:0] r_k_low, r_k_high;
    logic [5:0] r_thr;
    logic       en;

    assign o_cfg_ready = 1'b1;
    // Whole pipeline advances when the output word is free or taken.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_low  <= 3'd2;
            r_k_high <= 3'd3;
            r_thr    <= 6'd6;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_K_LOW:     r_k_low  <= i_cfg_data[2:0];
                REG_K_HIGH:    r_k_high <= i_cfg_data[2:0];
                REG_THRESHOLD: r_thr    <= i_cfg_data[5:0];
                default:       ;
            endcase
        end
    end

    logic        b_valid, b_cmd, b_skip, b_smooth;
    logic [2:0]  b_k;
    t_quad       b_pix, b_lsb, in_pix, s_best;
    logic [19:0] b_ext;
    logic        s_valid;

    assign in_pix = {i_pix_bottom_right, i_pix_bottom_left, i_pix_top_right, i_pix_top_left};

    fpd_classify #(.MAX_K(MAX_K)) u_cls (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_cmd(i_cmd), .i_pix(in_pix), .i_msg(i_msg_bits),
        .i_k_low(r_k_low), .i_k_high(r_k_high), .i_thr(r_thr),
        .o_valid(b_valid), .o_cmd(b_cmd), .o_skip(b_skip), .o_smooth(b_smooth),
        .o_k(b_k), .o_pix(b_pix), .o_lsb(b_lsb), .o_ext(b_ext)
    );

    fpd_search u_srch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(b_valid),
        .i_smooth(b_smooth), .i_k(b_k), .i_thr(r_thr), .i_pix(b_pix),
        .i_lsb(b_lsb), .o_valid(s_valid), .o_best(s_best)
    );

    // Side data delayed alongside the two search stages.
    logic        r_c_cmd, r_c_skip, r_d_cmd, r_d_skip;
    logic [2:0]  r_c_k, r_d_k;
    t_quad       r_c_pix, r_d_pix;
    logic [19:0] r_c_ext, r_d_ext;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_cmd <= b_cmd;  r_c_skip <= b_skip; r_c_k <= b_k;
            r_c_pix <= b_pix;  r_c_ext <= b_ext;
            r_d_cmd <= r_c_cmd; r_d_skip <= r_c_skip; r_d_k <= r_c_k;
            r_d_pix <= r_c_pix; r_d_ext <= r_c_ext;
        end
    end

    // Output stage.
    t_quad n_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= s_valid;
        end
        if (en) begin
            o_skip_block     <= r_d_skip;
            o_bits_used      <= r_d_skip ? 5'd0 : {r_d_k, 2'b00};
            o_extracted_bits <= (!r_d_skip && r_d_cmd == CMD_EXTRACT) ? r_d_ext : 20'd0;
            o_out_top_left     <= n_out[0];
            o_out_top_right    <= n_out[1];
            o_out_bottom_left  <= n_out[2];
            o_out_bottom_right <= n_out[3];
        end
    end
    assign n_out = (r_d_skip || r_d_cmd == CMD_EXTRACT) ? r_d_pix : s_best;

`ifndef SYNTHESIS
    // A skipped word carries no bits.
    a_skip_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_skip_block |-> o_bits_used == 5'd0 && o_extracted_bits == 20'd0)
        else $error("skipped word reports bits");
    // A held output word does not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_top_left) && $stable(o_bits_used))
        else $error("held output word changed");
    // Input stall only follows output stall.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back pressure");
`endif
endmodule
